// ===== src/deq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// Depends on nothing; every other file of the block imports it.
package deq_pkg;

   localparam int DEPTH  = 16;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_DUMP       = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_HOLD       = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_PUSH_BACK  = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_BACK   = 3'd4,
      CMD_ROTATE     = 3'd5
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type              cmd;
      logic signed [DATA_W-1:0] value;
   } chain_ctrl_type;

endpackage

// ===== src/double_ended_queue_top.sv =====
`timescale 1ns / 1ps
// Top level of the double-ended queue: request decode, dump sequencer and
// result register. Depends on deq_pkg and deq_chain.
//
// Usage:
// The request channel (req_) carries one operation per transfer: the op code
// in req_tuser and the value to push in req_tdata. The result channel (rsp_)
// returns the popped or dumped value in rsp_tdata, the status in rsp_tuser
// and marks the final result of each request with rsp_tlast.
// Entries live in a row of DEPTH cells, front in the first cell. A push at
// the front shifts the whole row back by one cell, a pop at the front shifts
// it forward, and pushes and pops at the back touch only the boundary cell.
// Push and pop requests give their result in the cycle after the request
// transfer, and a new request is taken as soon as the result register is
// free or being emptied, so these sustain one request a cycle.
// A dump rotates the row one cell per cycle while the result register is
// free and emits the front cell each time. The request moves the state to
// S_DUMP, where each step registers one result, so a dump of N entries gives
// N results and blocks new requests while it runs; after N rotations the
// order is restored. Unknown op codes are taken and dropped without a result.
// Reset (synchronous, active high) empties the queue and the result register.
// When the receiver stalls, the result stays in the output register and
// requests and dump steps wait until it is taken.
module double_ended_queue_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic [2:0]  req_tuser,  // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] value_res
   output logic [1:0]  rsp_tuser,  // [1:0] status
   output logic        rsp_tlast
);
   import deq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DUMP = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type               rsp_stat_ff, rsp_stat_in;
   logic                     rsp_last_ff, rsp_last_in;

   chain_ctrl_type           ctrl;
   logic signed [DATA_W-1:0] head_data, tail_data;
   logic                     out_free, accept, is_full, is_empty;
   op_type                   op;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty   = (count_ff == '0);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl.cmd     = CMD_HOLD;
      ctrl.value   = req_tdata;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Every result of a single-step request is final and, unless
               // noted below, carries a zero value.
               rsp_data_in = '0;
               rsp_last_in = 1'b1;
               unique case (op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_stat_in = STAT_FULL;
                     end else begin
                        rsp_stat_in = STAT_OK;
                        ctrl.cmd    = (op == OP_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_stat_in = STAT_EMPTY;
                     end else begin
                        rsp_stat_in = STAT_OK;
                        rsp_data_in = (op == OP_POP_FRONT) ? head_data : tail_data;
                        ctrl.cmd    = (op == OP_POP_FRONT) ? CMD_POP_FRONT : CMD_POP_BACK;
                        count_in    = count_ff - 1'b1;
                     end
                  end
                  OP_DUMP: begin
                     if (is_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_stat_in  = STAT_EMPTY;
                     end else begin
                        state_in  = S_DUMP;
                        remain_in = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = head_data;
               rsp_stat_in  = STAT_OK;
               rsp_last_in  = (remain_ff == CNT_W'(1));
               ctrl.cmd     = CMD_ROTATE;
               remain_in    = remain_ff - 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
   end

   deq_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .head_data (head_data),
      .tail_data (tail_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/deq_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the queue chain: an entry and its occupied flag.
// Depends on deq_pkg.
module deq_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  deq_pkg::cell_cmd_type            cmd,
   input  logic signed [deq_pkg::DATA_W-1:0] push_value,
   input  logic                             prev_valid,
   input  logic signed [deq_pkg::DATA_W-1:0] prev_data,
   input  logic                             next_valid,
   input  logic signed [deq_pkg::DATA_W-1:0] next_data,
   input  logic signed [deq_pkg::DATA_W-1:0] head_data,
   output logic                             valid,
   output logic signed [deq_pkg::DATA_W-1:0] data
);
   import deq_pkg::*;

   logic                     valid_ff, valid_in;
   logic signed [DATA_W-1:0] data_ff, data_in;

   // A cell is the back of the queue when it is occupied and its successor is not.
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (cmd)
         CMD_HOLD: begin
         end
         CMD_PUSH_FRONT: begin
            valid_in = prev_valid;
            data_in  = prev_data;
         end
         CMD_PUSH_BACK: begin
            if (!valid_ff && prev_valid) begin
               valid_in = 1'b1;
               data_in  = push_value;
            end
         end
         CMD_POP_FRONT: begin
            valid_in = next_valid;
            data_in  = next_data;
         end
         CMD_POP_BACK: begin
            if (valid_ff && !next_valid) begin
               valid_in = 1'b0;
            end
         end
         CMD_ROTATE: begin
            if (valid_ff) begin
               data_in = next_valid ? next_data : head_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

// ===== src/deq_chain.sv =====
`timescale 1ns / 1ps
// Row of DEPTH queue cells, front at cell 0, with head and back read-out.
// Depends on deq_pkg and deq_cell.
module deq_chain (
   input  logic                             clock,
   input  logic                             reset,
   input  deq_pkg::chain_ctrl_type          ctrl,
   output logic signed [deq_pkg::DATA_W-1:0] head_data,
   output logic signed [deq_pkg::DATA_W-1:0] tail_data
);
   import deq_pkg::*;

   logic                     valid_w [DEPTH];
   logic signed [DATA_W-1:0] data_w  [DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic                     pv, nv;
         logic signed [DATA_W-1:0] pd, nd;
         if (gi == 0) begin : g_first
            assign pv = 1'b1;
            assign pd = ctrl.value;
         end else begin : g_mid
            assign pv = valid_w[gi-1];
            assign pd = data_w[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign nv = 1'b0;
            assign nd = '0;
         end else begin : g_inner
            assign nv = valid_w[gi+1];
            assign nd = data_w[gi+1];
         end
         deq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (ctrl.cmd),
            .push_value (ctrl.value),
            .prev_valid (pv),
            .prev_data  (pd),
            .next_valid (nv),
            .next_data  (nd),
            .head_data  (data_w[0]),
            .valid      (valid_w[gi]),
            .data       (data_w[gi])
         );
      end
   endgenerate

   assign head_data = data_w[0];

   // Exactly one cell is the back when the queue is not empty, so an OR
   // over the masked entries selects it.
   always_comb begin
      tail_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (valid_w[i] && (i == DEPTH - 1 || !valid_w[(i + 1) % DEPTH])) begin
            tail_data = tail_data | data_w[i];
         end
      end
   end

endmodule

// ===== src/deq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_top.
module deq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import deq_pkg::*;

   // A stalled result holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // A refused request carries a zero value and ends its request.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata == '0 && rsp_tlast)
      else $error("non-ok result with data or without last");

   // Push and pop requests answer with one final result in the next cycle.
   a_single_step: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tuser == OP_PUSH_FRONT || req_tuser == OP_PUSH_BACK ||
       req_tuser == OP_POP_FRONT || req_tuser == OP_POP_BACK)
      |=> rsp_tvalid && rsp_tlast)
      else $error("push or pop result missing");

   // A push never returns the empty status.
   a_push_status: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tuser == OP_PUSH_FRONT || req_tuser == OP_PUSH_BACK)
      |=> rsp_tuser == STAT_OK || rsp_tuser == STAT_FULL)
      else $error("push returned a wrong status");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue_top: random pushes, pops and dumps
// with idle bursts on both channels, compared against an in-bench ring model.
// Depends on deq_pkg and the RTL of the block; reads no files.
module testbench;
   import deq_pkg::*;

   // One expected transfer on the result channel.
   typedef struct {
      logic signed [DATA_W-1:0] value;
      status_type               status;
      logic                     last;
   } deq_result_type;

   // Shadow of the deque: a ring of DEPTH entries with a head index and a fill
   // count. Every accepted request is run through it, and the results it should
   // cause are queued in order for the response monitor.
   class deque_tracker;
      logic signed [DATA_W-1:0] ring [DEPTH];
      int unsigned              head;
      int unsigned              fill;
      deq_result_type           awaited[$];
      int                       errors;

      function new();
         head   = 0;
         fill   = 0;
         errors = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void await_result(logic signed [DATA_W-1:0] v, status_type st, logic lst);
         deq_result_type r;
         r.value  = v;
         r.status = st;
         r.last   = lst;
         awaited.push_back(r);
      endfunction

      // Predict the results of one accepted request and update the shadow ring.
      function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
         int unsigned pos;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (fill == DEPTH) begin
                  await_result('0, STAT_FULL, 1'b1);
               end else begin
                  if (op == OP_PUSH_FRONT) begin
                     head       = (head + DEPTH - 1) % DEPTH;
                     ring[head] = val;
                  end else begin
                     ring[(head + fill) % DEPTH] = val;
                  end
                  fill++;
                  await_result('0, STAT_OK, 1'b1);
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (fill == 0) begin
                  await_result('0, STAT_EMPTY, 1'b1);
               end else begin
                  if (op == OP_POP_FRONT) begin
                     pos  = head;
                     head = (head + 1) % DEPTH;
                  end else begin
                     pos = (head + fill - 1) % DEPTH;
                  end
                  fill--;
                  await_result(ring[pos], STAT_OK, 1'b1);
               end
            end
            OP_DUMP: begin
               if (fill == 0) begin
                  await_result('0, STAT_EMPTY, 1'b1);
               end else begin
                  for (int unsigned i = 0; i < fill; i++)
                     await_result(ring[(head + i) % DEPTH], STAT_OK, i + 1 == fill);
               end
            end
            default: ;  // unused codes are dropped without a result
         endcase
      endfunction

      // Compare one accepted result transfer with the oldest expectation.
      task check_result(logic [DATA_W-1:0] data, logic [STAT_W-1:0] user, logic lst);
         deq_result_type r;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result data=%0d status=%0d last=%0b",
                             $signed(data), user, lst));
            return;
         end
         r = awaited.pop_front();
         if (data !== r.value)
            report($sformatf("data %0d, expected %0d", $signed(data), r.value));
         if (user !== r.status)
            report($sformatf("status %0d, expected %0d", user, r.status));
         if (lst !== r.last)
            report($sformatf("last %0b, expected %0b", lst, r.last));
      endtask
   endclass

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 256;
   localparam int QUIET_FROM   = 215;   // no idling on either side from here on
   localparam int SQUEEZE_AT   = 120;   // the long receiver hold-off starts here
   localparam int SQUEEZE_LEN  = 60;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]   req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0] rsp_tuser;
   logic              rsp_tlast;

   deque_tracker tracker = new();

   // Flags shared between the sender and the receiver process.
   logic req_seen   = 1'b0;   // a request transfer happened at the last rising edge
   logic quiet      = 1'b0;   // final stretch: both sides run without idling
   logic squeeze    = 1'b0;   // ask the receiver for its long hold-off
   int   cycle_count = 0;

   double_ended_queue_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Both monitors sample at the rising edge, so they see the values that were
   // present at the edge, before the block's registers update. A result is
   // registered after its request is taken, so it is never accepted in the same
   // edge as the request that caused it.
   always @(posedge clock) begin
      req_seen = !reset && req_tvalid && req_tready;
      if (req_seen)
         tracker.note_request(req_tuser, req_tdata);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Receiver. Ready changes only at the falling edge. It drops out in short
   // random bursts, and when the sender asks holds off for a long stretch so that
   // the result register stays full and the block has to stall its requests.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (squeeze) begin
            squeeze   = 1'b0;
            hold_left = SQUEEZE_LEN - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 8) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one request from a falling edge and wait until it is taken. Valid
   // is left high on return, so a back-to-back request needs no second write.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      do
         @(negedge clock);
      while (!req_seen);
   endtask

   // Optional idle burst on the request side, between two transfers.
   task automatic sender_pause();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   initial begin
      int               sent;
      int               mode;
      int               roll;
      int               push_pct;
      logic [OP_W-1:0]  op;
      logic [DATA_W-1:0] val;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: empty-queue corners first, then the one-entry corners,
      // the value extremes, the unused codes and a dump of a short queue.
      send_request(OP_DUMP,       32'h1234_5678);
      send_request(OP_POP_FRONT,  32'hFFFF_FFFF);
      send_request(OP_POP_BACK,   32'h0000_0000);
      // Push at the back of an empty queue, then pop the back of one entry.
      send_request(OP_PUSH_BACK,  32'h7FFF_FFFF);
      send_request(OP_POP_BACK,   32'h0000_0000);
      send_request(OP_PUSH_FRONT, 32'h8000_0000);
      sender_pause();
      send_request(OP_PUSH_BACK,  32'h0000_0000);
      send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      // Codes 5 to 7 are not operations and must vanish without a result.
      for (int c = OP_DUMP + 1; c < (1 << OP_W); c++)
         send_request(c[OP_W-1:0], $urandom);
      send_request(OP_DUMP,       32'h0000_0000);
      send_request(OP_POP_FRONT,  32'h0000_0000);
      sender_pause();
      send_request(OP_POP_BACK,   32'h0000_0000);

      // Random part. The push/pop balance changes every 32 requests, so the
      // queue swings between full and empty and both refusal cases recur.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet = (sent >= QUIET_FROM);
         if (sent == SQUEEZE_AT)
            squeeze = 1'b1;
         // The sender keeps offering without gaps while the receiver holds off.
         if (sent < SQUEEZE_AT || sent >= SQUEEZE_AT + 30)
            sender_pause();

         mode     = (sent / 32) % 3;
         push_pct = (mode == 0) ? 85 : (mode == 1) ? 20 : 50;
         roll     = $urandom_range(0, 99);
         if (roll < 3) begin
            op = OP_W'($urandom_range(OP_DUMP + 1, (1 << OP_W) - 1));
         end else if (roll < 11) begin
            op = OP_DUMP;
         end else if ($urandom_range(0, 99) < push_pct) begin
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         end else begin
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
         end

         case ($urandom_range(0, 11))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'hFFFF_FFFF;
            3:       val = 32'h0000_0000;
            default: val = $urandom;
         endcase

         send_request(op, val);
         // Dropped codes do not count toward the random quota.
         if (op <= OP_DUMP)
            sent++;
      end
      req_tvalid <= 1'b0;

      // Drain: wait for every expected result, then allow the longest dump
      // time for anything unexpected to show up.
      while (tracker.awaited.size() != 0)
         @(posedge clock);
      repeat (4 * DEPTH) @(posedge clock);

      if (tracker.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/deq_pkg.sv
src/deq_cell.sv
src/deq_chain.sv
src/double_ended_queue_top.sv
src/deq_checker.sv
bench/testbench.sv
